FILE: hw/rtl/pfr_pkg.sv
package pfr_pkg;

	localparam int TX_FRAME_BYTES  = 9;
	localparam int MAX_FRAME_BYTES = 42;
	localparam int MIN_FRAME_BYTES = 5;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int TX_IDX_W        = $clog2(TX_FRAME_BYTES);

	localparam logic [7:0] TX_START_BYTE = 8'h81;
	localparam logic [7:0] RX_START_BYTE = 8'h01;
	localparam logic [6:0] GROUP_MASK    = 7'h7F;
	localparam int         GROUP_SHIFT   = 7;
	localparam int         TOP_SHIFT     = 14;

	typedef enum logic [0:0] {
		CMD_SEND = 1'b0,
		CMD_RX   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_STATUS = 2'd2
	} rsp_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_CHECKSUM  = 3'd2,
		ST_RANGE     = 3'd3,
		ST_BAD_HEX   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		VK_SIGNED   = 2'd0,
		VK_BOOLEAN  = 2'd1,
		VK_UNSIGNED = 2'd2,
		VK_HEX      = 2'd3
	} value_kind_t;

	typedef enum logic [1:0] {
		REG_FRAME_LENGTH = 2'd0,
		REG_VALUE_KIND   = 2'd1,
		REG_MIN_LIMIT    = 2'd2,
		REG_MAX_LIMIT    = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  opcode;
		logic [15:0] address;
		logic [15:0] data_word;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic        last;
		logic [2:0]  status;
		logic [15:0] value;
	} rsp_t;

	typedef struct packed {
		logic [5:0]  frame_length;
		logic [1:0]  value_kind;
		logic [15:0] min_limit;
		logic [15:0] max_limit;
	} cfg_t;

	typedef struct packed {
		logic tx;
		logic one;
		rsp_t rsp;
	} emit_t;

endpackage

FILE: hw/rtl/pfr_core.sv
module pfr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  pfr_pkg::req_t req,
	input  pfr_pkg::cfg_t cfg,
	output pfr_pkg::emit_t emit
);

	logic [pfr_pkg::CNT_W-1:0] rx_count_q, rx_count_d;
	logic                      rx_armed_q, rx_armed_d;
	logic                      start_ok_q, start_ok_d;
	logic [7:0]                xor_acc_q, xor_acc_d;
	logic [15:0]               value_acc_q, value_acc_d;
	logic [3:0]                high_nibble_q, high_nibble_d;
	logic                      hex_bad_q, hex_bad_d;

	logic [5:0]                len6;
	logic [pfr_pkg::CNT_W-1:0] len;
	logic [7:0]                b;
	logic [4:0]                nib;
	pfr_pkg::status_t          st;
	logic                      range_ok;

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			return 5'(c - 8'h41 + 8'd10);
		end
		return 5'd16;
	endfunction

	assign b   = req.rx_byte;
	assign nib = hex_nibble(b);

	always_comb begin
		if (cfg.frame_length < 6'(pfr_pkg::MIN_FRAME_BYTES)) begin
			len6 = 6'(pfr_pkg::MIN_FRAME_BYTES);
		end else if (cfg.frame_length > 6'(pfr_pkg::MAX_FRAME_BYTES)) begin
			len6 = 6'(pfr_pkg::MAX_FRAME_BYTES);
		end else begin
			len6 = cfg.frame_length;
		end
	end

	assign len = pfr_pkg::CNT_W'(len6);

	always_comb begin
		range_ok = 1'b0;
		unique case (pfr_pkg::value_kind_t'(cfg.value_kind))
			pfr_pkg::VK_SIGNED: begin
				range_ok = ($signed(value_acc_q) >= $signed(cfg.min_limit)) &&
				           ($signed(value_acc_q) <= $signed(cfg.max_limit));
			end
			pfr_pkg::VK_BOOLEAN: begin
				range_ok = value_acc_q <= 16'd1;
			end
			pfr_pkg::VK_UNSIGNED: begin
				range_ok = (value_acc_q >= cfg.min_limit) && (value_acc_q <= cfg.max_limit);
			end
			pfr_pkg::VK_HEX: begin
				range_ok = !(hex_bad_q || len[0]);
			end
		endcase
	end

	always_comb begin
		priority if (!start_ok_q) begin
			st = pfr_pkg::ST_BAD_START;
		end else if (xor_acc_q != b) begin
			st = pfr_pkg::ST_CHECKSUM;
		end else if (range_ok) begin
			st = pfr_pkg::ST_OK;
		end else if (cfg.value_kind == pfr_pkg::VK_HEX) begin
			st = pfr_pkg::ST_BAD_HEX;
		end else begin
			st = pfr_pkg::ST_RANGE;
		end
	end

	always_comb begin
		rx_count_d    = rx_count_q;
		rx_armed_d    = rx_armed_q;
		start_ok_d    = start_ok_q;
		xor_acc_d     = xor_acc_q;
		value_acc_d   = value_acc_q;
		high_nibble_d = high_nibble_q;
		hex_bad_d     = hex_bad_q;
		emit          = '0;
		if (req.cmd == pfr_pkg::CMD_SEND) begin
			emit.tx       = 1'b1;
			rx_count_d    = '0;
			rx_armed_d    = 1'b1;
			start_ok_d    = 1'b0;
			xor_acc_d     = '0;
			value_acc_d   = '0;
			high_nibble_d = '0;
			hex_bad_d     = 1'b0;
		end else if (rx_armed_q) begin
			if (rx_count_q >= len - pfr_pkg::CNT_W'(1)) begin
				emit.one        = 1'b1;
				emit.rsp.kind   = pfr_pkg::KIND_STATUS;
				emit.rsp.status = st;
				emit.rsp.value  = (cfg.value_kind == pfr_pkg::VK_HEX) ? 16'd0 : value_acc_q;
				rx_armed_d      = 1'b0;
				rx_count_d      = '0;
			end else begin
				if (rx_count_q == '0) begin
					start_ok_d = (b == pfr_pkg::RX_START_BYTE);
				end else begin
					xor_acc_d = xor_acc_q ^ b;
					if (rx_count_q <= pfr_pkg::CNT_W'(3)) begin
						value_acc_d = (value_acc_q << pfr_pkg::GROUP_SHIFT) + {8'd0, b};
					end
					if (cfg.value_kind == pfr_pkg::VK_HEX) begin
						hex_bad_d = hex_bad_q | nib[4];
						if (rx_count_q[0]) begin
							high_nibble_d = nib[3:0];
						end else if (!hex_bad_d) begin
							emit.one          = 1'b1;
							emit.rsp.kind     = pfr_pkg::KIND_TEXT;
							emit.rsp.out_byte = {high_nibble_q, nib[3:0]};
						end
					end
				end
				rx_count_d = rx_count_q + pfr_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q    <= '0;
			rx_armed_q    <= 1'b0;
			start_ok_q    <= 1'b0;
			xor_acc_q     <= '0;
			value_acc_q   <= '0;
			high_nibble_q <= '0;
			hex_bad_q     <= 1'b0;
		end else if (accept) begin
			rx_count_q    <= rx_count_d;
			rx_armed_q    <= rx_armed_d;
			start_ok_q    <= start_ok_d;
			xor_acc_q     <= xor_acc_d;
			value_acc_q   <= value_acc_d;
			high_nibble_q <= high_nibble_d;
			hex_bad_q     <= hex_bad_d;
		end
	end

endmodule

FILE: hw/rtl/pfr_out.sv
module pfr_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  pfr_pkg::emit_t emit,
	input  pfr_pkg::req_t  req,
	output logic           ready,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfr_pkg::rsp_t  rsp
);

	localparam logic [pfr_pkg::TX_IDX_W-1:0] TX_LAST =
		pfr_pkg::TX_IDX_W'(pfr_pkg::TX_FRAME_BYTES - 1);

	logic                         job_v_q;
	logic                         job_tx_q;
	logic [pfr_pkg::TX_IDX_W-1:0] idx_q;
	logic [7:0]                   opcode_q;
	logic [15:0]                  address_q;
	logic [15:0]                  data_q;
	pfr_pkg::rsp_t                one_q;

	logic       load;
	logic       take;
	logic       finishing;
	logic [6:0] g [6];
	logic [7:0] tx_byte;

	assign g[0] = {5'd0, address_q[15:pfr_pkg::TOP_SHIFT]};
	assign g[1] = address_q[pfr_pkg::TOP_SHIFT-1:pfr_pkg::GROUP_SHIFT] & pfr_pkg::GROUP_MASK;
	assign g[2] = address_q[pfr_pkg::GROUP_SHIFT-1:0] & pfr_pkg::GROUP_MASK;
	assign g[3] = {5'd0, data_q[15:pfr_pkg::TOP_SHIFT]};
	assign g[4] = data_q[pfr_pkg::TOP_SHIFT-1:pfr_pkg::GROUP_SHIFT] & pfr_pkg::GROUP_MASK;
	assign g[5] = data_q[pfr_pkg::GROUP_SHIFT-1:0] & pfr_pkg::GROUP_MASK;

	always_comb begin
		unique case (idx_q)
			4'd0:    tx_byte = pfr_pkg::TX_START_BYTE;
			4'd1:    tx_byte = opcode_q;
			4'd2:    tx_byte = {1'b0, g[0]};
			4'd3:    tx_byte = {1'b0, g[1]};
			4'd4:    tx_byte = {1'b0, g[2]};
			4'd5:    tx_byte = {1'b0, g[3]};
			4'd6:    tx_byte = {1'b0, g[4]};
			4'd7:    tx_byte = {1'b0, g[5]};
			4'd8:    tx_byte = {1'b0, g[0] ^ g[1] ^ g[2] ^ g[3] ^ g[4] ^ g[5]};
			default: tx_byte = '0;
		endcase
	end

	assign take      = rsp_valid && !rsp_stall;
	assign finishing = job_v_q && (!job_tx_q || idx_q == TX_LAST);
	assign ready     = !job_v_q || (take && finishing);
	assign load      = accept && (emit.tx || emit.one);
	assign rsp_valid = job_v_q;

	always_comb begin
		if (job_tx_q) begin
			rsp          = '0;
			rsp.kind     = pfr_pkg::KIND_TX;
			rsp.out_byte = tx_byte;
			rsp.last     = (idx_q == TX_LAST);
		end else begin
			rsp = one_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q  <= 1'b0;
			job_tx_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			job_v_q  <= 1'b1;
			job_tx_q <= emit.tx;
			idx_q    <= '0;
		end else if (take) begin
			if (finishing) begin
				job_v_q <= 1'b0;
			end else begin
				idx_q <= idx_q + pfr_pkg::TX_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			opcode_q  <= req.opcode;
			address_q <= req.address;
			data_q    <= req.data_word;
			one_q     <= emit.rsp;
		end
	end

endmodule

FILE: hw/rtl/packed_frame_request_response_engine.sv
// Request/response framing engine. A send request puts out a 9-byte transmit
// run (start byte, opcode, address and data in 7-bit groups, XOR checksum) and
// arms the receiver; each received-byte request while armed builds up the
// response frame and gives at most one result: a decoded text byte, or the
// frame status with the unpacked value (zero in hex mode) when the frame
// completes. A new request is taken every cycle while the response output is
// not stalled; a send request holds the single output register for nine accepted
// transfers, and the next request waits until the last transmit byte is taken.
// Configuration registers take writes at any cycle (ready is always high) and
// are meant to be written only while the engine is idle.
module packed_frame_request_response_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pfr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pfr_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	pfr_pkg::cfg_t  cfg_q;
	pfr_pkg::emit_t emit;
	logic           ready;
	logic           accept;

	assign cfg_ready = 1'b1;
	assign req_stall = !ready;
	assign accept    = req_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length <= 6'(pfr_pkg::MIN_FRAME_BYTES);
			cfg_q.value_kind   <= pfr_pkg::VK_SIGNED;
			cfg_q.min_limit    <= 16'h0000;
			cfg_q.max_limit    <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pfr_pkg::reg_index_t'(cfg_index))
				pfr_pkg::REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data[5:0];
				pfr_pkg::REG_VALUE_KIND:   cfg_q.value_kind   <= cfg_data[1:0];
				pfr_pkg::REG_MIN_LIMIT:    cfg_q.min_limit    <= cfg_data;
				pfr_pkg::REG_MAX_LIMIT:    cfg_q.max_limit    <= cfg_data;
			endcase
		end
	end

	pfr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cfg    (cfg_q),
		.emit   (emit)
	);

	pfr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.emit      (emit),
		.req       (req),
		.ready     (ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
